/* hw/rtl/mteu_pkg.sv */
// mteu_pkg: shared types, codes and sizing for the multi-timer expiry unit.
// No dependencies; imported by multi_timer_expiry_unit_core.
`default_nettype none

package mteu_pkg;

   // pool sizing
   localparam int TIMER_SLOTS = 32;
   localparam int SLOT_CAP    = 32;
   localparam int LIVE_SLOTS  = (TIMER_SLOTS < SLOT_CAP) ? TIMER_SLOTS : SLOT_CAP;
   localparam int SLOT_IDX_W  = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;

   // field widths
   localparam int OP_W   = 3;
   localparam int SLOT_W = 5;
   localparam int CHAN_W = 4;
   localparam int DATA_W = 8;
   localparam int TIME_W = 32;

   // operations
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
   localparam logic [OP_W-1:0] OP_INIT    = 3'd2;
   localparam logic [OP_W-1:0] OP_SETTIME = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   // result kinds
   localparam logic [OP_W-1:0] KIND_ALLOC_OK   = 3'd0;
   localparam logic [OP_W-1:0] KIND_ALLOC_FAIL = 3'd1;
   localparam logic [OP_W-1:0] KIND_ACK        = 3'd2;
   localparam logic [OP_W-1:0] KIND_EXPIRY     = 3'd3;
   localparam logic [OP_W-1:0] KIND_TICK_DONE  = 3'd4;

   // slot status
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_ARMED = 2'd2;

   // CSR register indexes
   localparam logic REG_TASK_SLOT   = 1'b0;
   localparam logic REG_TASK_ENABLE = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] stamp;
   } timer_entry_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] payload;
   } info_entry_type;

endpackage

`default_nettype wire

/* hw/rtl/mteu_ram.sv */
// mteu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mteu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/multi_timer_expiry_unit_core.sv */
// Alloc, free, init, settime and unknown ops answer in the cycle after the item is taken.
// Tick: each scan pass reads every slot's timer entry; a tick that fires k timers runs
// k + 1 passes plus one expiry result per delivered timer and a closing tick-done result.
// Throughput: one item at a time, bounded by the single read port of the timer RAM.
// Reset: synchronous, active high; all slots free, tick count, arm sequence and CSRs zero.
// Depends on mteu_pkg and mteu_ram.
`default_nettype none

module multi_timer_expiry_unit_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input item channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [mteu_pkg::OP_W-1:0]     req_operation,
   input  wire logic [mteu_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [mteu_pkg::CHAN_W-1:0]   req_channel,
   input  wire logic [mteu_pkg::DATA_W-1:0]   req_payload,
   input  wire logic [mteu_pkg::TIME_W-1:0]   req_delay,
   // result item channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [mteu_pkg::OP_W-1:0]     rsp_kind,
   output      logic [mteu_pkg::SLOT_W-1:0]   rsp_result_slot,
   output      logic [mteu_pkg::CHAN_W-1:0]   rsp_result_channel,
   output      logic [mteu_pkg::DATA_W-1:0]   rsp_result_payload,
   output      logic                          rsp_switch_task,
   output      logic                          rsp_last,
   // APB-style configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output      logic [31:0]                   prdata,
   output      logic                          pready
);

   import mteu_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // take items, finish simple ops at once
   localparam logic [2:0] S_PASS   = 3'd1;  // issue one timer RAM read per cycle
   localparam logic [2:0] S_DRAIN  = 3'd2;  // last read of the pass comes back
   localparam logic [2:0] S_SELECT = 3'd3;  // fire best candidate or finish
   localparam logic [2:0] S_EMIT   = 3'd4;  // deliver expiry with channel/payload
   localparam logic [2:0] S_DONE   = 3'd5;  // closing tick-done item

   localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(LIVE_SLOTS - 1);
   localparam int TMR_W  = $bits(timer_entry_type);
   localparam int INFO_W = $bits(info_entry_type);

   // control / state registers
   logic [2:0]              state_ff, state_in;
   logic [TIME_W-1:0]       tick_count_ff, tick_count_in;
   logic [TIME_W-1:0]       arm_seq_ff, arm_seq_in;
   logic [1:0]              status_ff [LIVE_SLOTS];
   logic [1:0]              status_in [LIVE_SLOTS];
   logic [SLOT_W-1:0]       task_slot_ff, task_slot_in;
   logic                    task_en_ff, task_en_in;

   // scan machinery
   logic [SLOT_IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [SLOT_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                    first_pass_ff, first_pass_in;
   logic [LIVE_SLOTS-1:0]   due_ff, due_in;
   logic                    best_vld_ff, best_vld_in;
   logic [SLOT_IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]       best_dl_ff, best_dl_in;
   logic [TIME_W-1:0]       best_stamp_ff, best_stamp_in;
   logic                    sw_ff, sw_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [CHAN_W-1:0]       rsp_chan_ff, rsp_chan_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_sw_ff, rsp_sw_in;
   logic                    rsp_last_ff, rsp_last_in;

   // RAM ports
   logic                    tmr_wr_en, tmr_rd_en;
   timer_entry_type         tmr_wr_data, tmr_rd_data;
   logic                    info_wr_en, info_rd_en;
   info_entry_type          info_wr_data, info_rd_data;

   // misc comb
   logic                    out_free;
   logic                    req_accept;
   logic                    slot_ok;
   logic [SLOT_IDX_W-1:0]   slot_idx;
   logic                    free_found;
   logic [SLOT_IDX_W-1:0]   free_idx;
   logic                    cand_due;
   logic                    cand_better;
   logic                    task_hit;
   logic                    csr_wr;

   // deadline + arm stamp per slot
   mteu_ram #(
      .WIDTH (TMR_W),
      .DEPTH (LIVE_SLOTS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (tmr_wr_en),
      .wr_addr (slot_idx),
      .wr_data (tmr_wr_data),
      .rd_en   (tmr_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (tmr_rd_data)
   );

   // delivery channel + data byte per slot; read only for the slot being fired
   mteu_ram #(
      .WIDTH (INFO_W),
      .DEPTH (LIVE_SLOTS)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (info_wr_en),
      .wr_addr (slot_idx),
      .wr_data (info_wr_data),
      .rd_en   (info_rd_en),
      .rd_addr (best_idx_ff),
      .rd_data (info_rd_data)
   );

   // ---------------------------------------------------------------
   // CSR port: always ready, register index is paddr[2]
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      task_slot_in = task_slot_ff;
      task_en_in   = task_en_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_TASK_SLOT:   task_slot_in = pwdata[SLOT_W-1:0];
            REG_TASK_ENABLE: task_en_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TASK_SLOT:   prdata = {{(32-SLOT_W){1'b0}}, task_slot_ff};
         REG_TASK_ENABLE: prdata = {31'b0, task_en_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------
   // output register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign slot_ok  = int'(req_slot) < LIVE_SLOTS;
   assign slot_idx = req_slot[SLOT_IDX_W-1:0];

   // lowest free slot for alloc
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = LIVE_SLOTS - 1; i >= 0; i--) begin
         if (status_ff[i] == ST_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(i);
         end
      end
   end

   // candidate from the timer RAM read that came back this cycle.
   // First pass also latches the due set; later passes reuse it.
   always_comb begin
      if (first_pass_ff) begin
         cand_due = (status_ff[rd_idx_ff] == ST_ARMED) &&
                    (tmr_rd_data.deadline <= tick_count_ff);
      end else begin
         cand_due = due_ff[rd_idx_ff];
      end
      // earlier deadline wins; on a tie the later arm stamp wins;
      // equal stamps keep the lower slot since the scan runs upward
      cand_better = !best_vld_ff ||
                    (tmr_rd_data.deadline < best_dl_ff) ||
                    ((tmr_rd_data.deadline == best_dl_ff) &&
                     (tmr_rd_data.stamp > best_stamp_ff));
   end

   assign task_hit = task_en_ff && (SLOT_W'(best_idx_ff) == task_slot_ff);

   assign tmr_wr_data.deadline = tick_count_ff + req_delay;
   assign tmr_wr_data.stamp    = arm_seq_ff;
   assign info_wr_data.channel = req_channel;
   assign info_wr_data.payload = req_payload;

   // ---------------------------------------------------------------
   // main sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      tick_count_in = tick_count_ff;
      arm_seq_in    = arm_seq_ff;
      status_in     = status_ff;
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      first_pass_in = first_pass_ff;
      due_in        = due_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_stamp_in = best_stamp_ff;
      sw_in         = sw_ff;

      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_last_in   = rsp_last_ff;

      tmr_wr_en     = 1'b0;
      tmr_rd_en     = 1'b0;
      info_wr_en    = 1'b0;
      info_rd_en    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // fold returning read into the running best
      if (rd_vld_ff) begin
         if (first_pass_ff) begin
            due_in[rd_idx_ff] = cand_due;
         end
         if (cand_due && cand_better) begin
            best_vld_in   = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_dl_in    = tmr_rd_data.deadline;
            best_stamp_in = tmr_rd_data.stamp;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               // default answer: single ack
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_slot_in  = '0;
               rsp_chan_in  = '0;
               rsp_data_in  = '0;
               rsp_sw_in    = 1'b0;
               rsp_last_in  = 1'b1;
               unique case (req_operation)
                  OP_ALLOC: begin
                     if (free_found) begin
                        status_in[free_idx] = ST_ALLOC;
                        rsp_kind_in = KIND_ALLOC_OK;
                        rsp_slot_in = SLOT_W'(free_idx);
                     end else begin
                        rsp_kind_in = KIND_ALLOC_FAIL;
                     end
                  end
                  OP_FREE: begin
                     // due set is rebuilt every tick, so clearing status unlinks
                     if (slot_ok) begin
                        status_in[slot_idx] = ST_FREE;
                     end
                  end
                  OP_INIT: begin
                     info_wr_en = slot_ok;
                  end
                  OP_SETTIME: begin
                     if (slot_ok && (status_ff[slot_idx] != ST_FREE)) begin
                        tmr_wr_en           = 1'b1;
                        arm_seq_in          = arm_seq_ff + 1'b1;
                        status_in[slot_idx] = ST_ARMED;
                     end
                  end
                  OP_TICK: begin
                     rsp_valid_in  = 1'b0;
                     tick_count_in = tick_count_ff + 1'b1;
                     scan_idx_in   = '0;
                     first_pass_in = 1'b1;
                     best_vld_in   = 1'b0;
                     sw_in         = 1'b0;
                     state_in      = S_PASS;
                  end
                  default: ;  // unknown op: plain ack
               endcase
            end
         end

         S_PASS: begin
            tmr_rd_en = 1'b1;
            rd_vld_in = 1'b1;
            rd_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         S_DRAIN: begin
            state_in = S_SELECT;
         end

         S_SELECT: begin
            first_pass_in = 1'b0;
            if (!best_vld_ff) begin
               state_in = S_DONE;
            end else begin
               status_in[best_idx_ff] = ST_ALLOC;
               due_in[best_idx_ff]    = 1'b0;
               if (task_hit) begin
                  // task timer: no delivery, flag goes on tick done
                  sw_in       = 1'b1;
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  state_in    = S_PASS;
               end else begin
                  info_rd_en = 1'b1;
                  state_in   = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EXPIRY;
               rsp_slot_in  = SLOT_W'(best_idx_ff);
               rsp_chan_in  = info_rd_data.channel;
               rsp_data_in  = info_rd_data.payload;
               rsp_sw_in    = 1'b0;
               rsp_last_in  = 1'b0;
               scan_idx_in  = '0;
               best_vld_in  = 1'b0;
               state_in     = S_PASS;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TICK_DONE;
               rsp_slot_in  = '0;
               rsp_chan_in  = '0;
               rsp_data_in  = '0;
               rsp_sw_in    = sw_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_count_ff <= '0;
         arm_seq_ff    <= '0;
         for (int i = 0; i < LIVE_SLOTS; i++) begin
            status_ff[i] <= ST_FREE;
         end
         task_slot_ff  <= '0;
         task_en_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         first_pass_ff <= 1'b0;
         best_vld_ff   <= 1'b0;
         sw_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_count_ff <= tick_count_in;
         arm_seq_ff    <= arm_seq_in;
         status_ff     <= status_in;
         task_slot_ff  <= task_slot_in;
         task_en_ff    <= task_en_in;
         rd_vld_ff     <= rd_vld_in;
         first_pass_ff <= first_pass_in;
         best_vld_ff   <= best_vld_in;
         sw_ff         <= sw_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and scan datapath, no reset needed
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      due_ff        <= due_in;
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      best_stamp_ff <= best_stamp_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_result_slot    = rsp_slot_ff;
   assign rsp_result_channel = rsp_chan_ff;
   assign rsp_result_payload = rsp_data_ff;
   assign rsp_switch_task    = rsp_sw_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

/* test/multi_timer_expiry_unit_core_check.sv */
// Scoreboard for the multi-timer expiry unit: follows both item channels and the APB port.
// Keeps its own copy of the timer pool and owes results in the order the block must give them.
// Depends on mteu_pkg.

module multi_timer_expiry_unit_core_check
   import mteu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [OP_W-1:0]   req_operation,
   input  wire logic [SLOT_W-1:0] req_slot,
   input  wire logic [CHAN_W-1:0] req_channel,
   input  wire logic [DATA_W-1:0] req_payload,
   input  wire logic [TIME_W-1:0] req_delay,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [OP_W-1:0]   rsp_kind,
   input  wire logic [SLOT_W-1:0] rsp_result_slot,
   input  wire logic [CHAN_W-1:0] rsp_result_channel,
   input  wire logic [DATA_W-1:0] rsp_result_payload,
   input  wire logic              rsp_switch_task,
   input  wire logic              rsp_last,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   input  wire logic              pready,
   output int                     owed_count,
   output int                     mismatches
);

   typedef struct packed {
      logic [OP_W-1:0]   kind;
      logic [SLOT_W-1:0] slot;
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] payload;
      logic              switch_task;
      logic              last;
   } timer_result_type;

   timer_result_type  owed[$];

   logic [TIME_W-1:0] now_tick;
   logic [TIME_W-1:0] arm_seq;
   logic [1:0]        status  [SLOT_CAP];
   logic [TIME_W-1:0] due_at  [SLOT_CAP];
   logic [TIME_W-1:0] armed_at[SLOT_CAP];
   logic [CHAN_W-1:0] chan_of [SLOT_CAP];
   logic [DATA_W-1:0] data_of [SLOT_CAP];
   logic [SLOT_W-1:0] switch_slot;
   logic              switch_en;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   function automatic void owe(input logic [OP_W-1:0] kind, input int slot,
                               input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] data,
                               input logic sw, input logic last);
      timer_result_type r;
      r.kind        = kind;
      r.slot        = SLOT_W'(slot);
      r.channel     = chan;
      r.payload     = data;
      r.switch_task = sw;
      r.last        = last;
      owed.push_back(r);
   endfunction

   // earlier deadline first, then the later arm, then the lower slot
   function automatic logic fires_first(input int a, input int b);
      if (due_at[a] != due_at[b]) return due_at[a] < due_at[b];
      if (armed_at[a] != armed_at[b]) return armed_at[a] > armed_at[b];
      return a < b;
   endfunction

   task automatic advance_timers(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                 input logic [CHAN_W-1:0] chan,
                                 input logic [DATA_W-1:0] data,
                                 input logic [TIME_W-1:0] dly);
      logic                live;
      logic [SLOT_CAP-1:0] ripe;
      logic                sw;
      int                  best;
      live = slot < LIVE_SLOTS;
      if (op == OP_ALLOC) begin
         best = -1;
         for (int i = 0; i < LIVE_SLOTS; i++)
            if (best < 0 && status[i] == ST_FREE) best = i;
         if (best >= 0) begin
            status[best] = ST_ALLOC;
            owe(KIND_ALLOC_OK, best, '0, '0, 1'b0, 1'b1);
         end else begin
            owe(KIND_ALLOC_FAIL, 0, '0, '0, 1'b0, 1'b1);
         end
      end else if (op == OP_TICK) begin
         now_tick = now_tick + 1'b1;
         sw = 1'b0;
         for (int i = 0; i < SLOT_CAP; i++)
            ripe[i] = i < LIVE_SLOTS && status[i] == ST_ARMED && due_at[i] <= now_tick;
         do begin
            best = -1;
            for (int i = 0; i < SLOT_CAP; i++)
               if (ripe[i] && (best < 0 || fires_first(i, best))) best = i;
            if (best >= 0) begin
               ripe[best] = 1'b0;
               status[best] = ST_ALLOC;
               if (switch_en && best == switch_slot) sw = 1'b1;
               else owe(KIND_EXPIRY, best, chan_of[best], data_of[best], 1'b0, 1'b0);
            end
         end while (best >= 0);
         owe(KIND_TICK_DONE, 0, '0, '0, sw, 1'b1);
      end else begin
         case (op)
            OP_FREE: begin
               if (live) status[slot] = ST_FREE;
            end
            OP_INIT: begin
               if (live) begin
                  chan_of[slot] = chan;
                  data_of[slot] = data;
               end
            end
            OP_SETTIME: begin
               if (live && status[slot] != ST_FREE) begin
                  due_at[slot]   = now_tick + dly;
                  armed_at[slot] = arm_seq;
                  arm_seq        = arm_seq + 1'b1;
                  status[slot]   = ST_ARMED;
               end
            end
            default: ;
         endcase
         owe(KIND_ACK, 0, '0, '0, 1'b0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         owed.delete();
         mismatches  = 0;
         now_tick    = '0;
         arm_seq     = '0;
         switch_slot = '0;
         switch_en   = 1'b0;
         for (int i = 0; i < SLOT_CAP; i++) begin
            status[i]   = ST_FREE;
            due_at[i]   = '0;
            armed_at[i] = '0;
            chan_of[i]  = '0;
            data_of[i]  = '0;
         end
      end else begin
         // results first: nothing taken at this edge can already be answered
         if (rsp_valid && !rsp_stall) begin
            if (owed.size() == 0) begin
               report_mismatch($sformatf("result kind %0h slot %0d with nothing owed",
                                         rsp_kind, rsp_result_slot));
            end else begin
               want = owed.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("slot", 32'(rsp_result_slot), 32'(want.slot));
               check_field("channel", 32'(rsp_result_channel), 32'(want.channel));
               check_field("payload", 32'(rsp_result_payload), 32'(want.payload));
               check_field("switch_task", 32'(rsp_switch_task), 32'(want.switch_task));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_TASK_ENABLE) switch_en = pwdata[0];
            else switch_slot = pwdata[SLOT_W-1:0];
         end
         if (req_valid && !req_stall)
            advance_timers(req_operation, req_slot, req_channel, req_payload, req_delay);
      end
      owed_count <= owed.size();
   end

endmodule

/* test/multi_timer_expiry_unit_core_test.sv */
// Testbench top for multi_timer_expiry_unit_core: clock, reset, item and APB stimulus, verdict.
// Checking is done by multi_timer_expiry_unit_core_check; depends on mteu_pkg and the RTL.

module multi_timer_expiry_unit_core_test;
   import mteu_pkg::*;

   // cycles with no item moving on either channel before the run is declared hung;
   // a full tick scan between results takes far fewer cycles, so this is ample
   localparam int IDLE_LIMIT = 3000;

   // operation codes the block does not define; they must only be acked
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   // register i sits at byte address 4*i
   localparam logic [2:0] ADDR_TASK_SLOT   = {REG_TASK_SLOT, 2'b00};
   localparam logic [2:0] ADDR_TASK_ENABLE = {REG_TASK_ENABLE, 2'b00};

   // random items per phase
   localparam int RANDOM_ITEMS = 33;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation = '0;
   logic [SLOT_W-1:0] req_slot      = '0;
   logic [CHAN_W-1:0] req_channel   = '0;
   logic [DATA_W-1:0] req_payload   = '0;
   logic [TIME_W-1:0] req_delay     = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [OP_W-1:0]   rsp_kind;
   logic [SLOT_W-1:0] rsp_result_slot;
   logic [CHAN_W-1:0] rsp_result_channel;
   logic [DATA_W-1:0] rsp_result_payload;
   logic              rsp_switch_task;
   logic              rsp_last;

   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [2:0]        paddr   = '0;
   logic [31:0]       pwdata  = '0;
   logic [31:0]       prdata;
   logic              pready;

   int                owed_count;
   int                mismatches;
   int                quiet_cycles = 0;

   // idle odds, in percent, for the sender and for the result stall
   int                send_idle_pct = 0;
   int                hold_pct      = 0;

   // slots that have seen an init; only these are ever armed, so no timer
   // can fire with its channel and data still unwritten
   logic [SLOT_CAP-1:0] primed = '0;

   always #5 clock = ~clock;

   multi_timer_expiry_unit_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_channel        (req_channel),
      .req_payload        (req_payload),
      .req_delay          (req_delay),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_result_channel (rsp_result_channel),
      .rsp_result_payload (rsp_result_payload),
      .rsp_switch_task    (rsp_switch_task),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   multi_timer_expiry_unit_core_check i_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_channel        (req_channel),
      .req_payload        (req_payload),
      .req_delay          (req_delay),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_result_channel (rsp_result_channel),
      .rsp_result_payload (rsp_result_payload),
      .rsp_switch_task    (rsp_switch_task),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .owed_count         (owed_count),
      .mismatches         (mismatches)
   );

   // result side backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < hold_pct);
   end

   // hang detector: any item moving on either side clears the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("multi_timer_expiry_unit_core_test failed");
         $finish;
      end
   end

   // APB write with setup and access phases; the register takes the value at the access edge
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one item, with random idle cycles in front, and hold it until taken.
   // valid stays high across back-to-back items; it only drops in an idle cycle.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] data,
                            input logic [TIME_W-1:0] dly);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= slot;
      req_channel   <= chan;
      req_payload   <= data;
      req_delay     <= dly;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_INIT) primed[slot] = 1'b1;
   endtask

   // Random item mix. Slots lean low since alloc hands out the lowest free one;
   // delays are mostly short so timers really fire and tie, with some huge
   // ones that never fire and some near 2^32 that wrap into the past.
   task automatic send_random();
      int                pick;
      int                shape;
      logic [SLOT_W-1:0] s;
      logic [TIME_W-1:0] d;
      pick  = $urandom_range(99);
      shape = $urandom_range(9);
      s = ($urandom_range(9) < 3) ? SLOT_W'($urandom_range(SLOT_CAP - 1))
                                  : SLOT_W'($urandom_range(9));
      if (shape < 6)      d = TIME_W'($urandom_range(6));
      else if (shape < 8) d = TIME_W'($urandom_range(40));
      else if (shape < 9) d = $urandom;
      else                d = 32'hffff_ffff - TIME_W'($urandom_range(3));
      if (pick < 12)
         send_item(OP_ALLOC, SLOT_W'($urandom), CHAN_W'($urandom), DATA_W'($urandom), $urandom);
      else if (pick < 20)
         send_item(OP_FREE, s, CHAN_W'($urandom), DATA_W'($urandom), $urandom);
      else if (pick < 36 || (pick < 62 && !primed[s]))
         send_item(OP_INIT, s, CHAN_W'($urandom), DATA_W'($urandom), $urandom);
      else if (pick < 62)
         send_item(OP_SETTIME, s, CHAN_W'($urandom), DATA_W'($urandom), d);
      else if (pick < 95)
         send_item(OP_TICK, SLOT_W'($urandom), CHAN_W'($urandom), DATA_W'($urandom), $urandom);
      else
         send_item(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), SLOT_W'($urandom),
                   CHAN_W'($urandom), DATA_W'($urandom), $urandom);
   endtask

   // drop valid, wait for every owed result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
      repeat (LIVE_SLOTS + 8) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 1: task slot 0 in force; sender idles 35%, receiver stalls 50%
      csr_write(ADDR_TASK_SLOT, 32'd0);
      csr_write(ADDR_TASK_ENABLE, 32'd1);
      send_idle_pct = 35;
      hold_pct      = 50;

      // directed: take slots 0..2, set channel/data extremes, slot 31 for later
      send_item(OP_ALLOC, '0, '0, '0, '0);
      send_item(OP_ALLOC, '1, '1, '1, '1);
      send_item(OP_ALLOC, '0, '0, '0, '0);
      send_item(OP_INIT, 5'd0, 4'hf, 8'hff, '0);
      send_item(OP_INIT, 5'd1, 4'h0, 8'h00, '1);
      send_item(OP_INIT, 5'd2, 4'ha, 8'h5a, '0);
      send_item(OP_INIT, 5'd31, 4'h5, 8'ha5, '0);
      // zero delay on the task slot: next tick asks for a switch, no delivery
      send_item(OP_SETTIME, 5'd0, '0, '0, 32'd0);
      // equal deadlines: slot 2 was armed later and must fire first
      send_item(OP_SETTIME, 5'd1, '0, '0, 32'd2);
      send_item(OP_SETTIME, 5'd2, '0, '0, 32'd2);
      send_item(OP_TICK, '0, '0, '0, '0);
      send_item(OP_TICK, '1, '1, '1, '1);
      send_item(OP_TICK, '0, '0, '0, '0);
      // arming a free slot and freeing a free slot change nothing
      send_item(OP_SETTIME, 5'd5, '0, '0, 32'd3);
      send_item(OP_FREE, 5'd31, '0, '0, '0);
      // largest delay wraps to a deadline already behind the count
      send_item(OP_SETTIME, 5'd1, '0, '0, 32'hffff_ffff);
      // armed then freed: must be unlinked and never fire
      send_item(OP_SETTIME, 5'd2, '0, '0, 32'h8000_0000);
      send_item(OP_FREE, 5'd2, '0, '0, '0);
      // re-arm replaces the old deadline
      send_item(OP_SETTIME, 5'd0, '0, '0, 32'd9);
      send_item(OP_SETTIME, 5'd0, '0, '0, 32'd1);
      send_item(OP_TICK, '0, '0, '0, '0);
      send_item(OP_SPARE_FIRST, '1, '1, '1, '1);
      send_item(OP_SPARE_LAST, '0, '0, '0, '0);
      send_item(OP_TICK, '0, '0, '0, '0);
      repeat (RANDOM_ITEMS) send_random();
      drain();

      // phase 2: task timer off; sender idles 50%, receiver stalls 35%
      csr_write(ADDR_TASK_SLOT, 32'd2);
      csr_write(ADDR_TASK_ENABLE, 32'd0);
      send_idle_pct = 50;
      hold_pct      = 35;
      repeat (RANDOM_ITEMS) send_random();
      drain();

      // phase 3: task slot at the top of the pool, no idling on either side
      csr_write(ADDR_TASK_SLOT, 32'd31);
      csr_write(ADDR_TASK_ENABLE, 32'd1);
      send_idle_pct = 0;
      hold_pct      = 0;
      // fill the pool until alloc fails, then fire slot 31 as the task timer
      repeat (SLOT_CAP + 2)
         send_item(OP_ALLOC, SLOT_W'($urandom), CHAN_W'($urandom), DATA_W'($urandom), $urandom);
      send_item(OP_SETTIME, 5'd31, '0, '0, 32'd1);
      send_item(OP_TICK, '0, '0, '0, '0);
      send_item(OP_TICK, '0, '0, '0, '0);
      repeat (RANDOM_ITEMS) send_random();
      drain();

      @(negedge clock);
      if (mismatches == 0) begin
         $display("multi_timer_expiry_unit_core_test passed");
      end else begin
         $display("multi_timer_expiry_unit_core_test failed");
      end
      $finish;
   end

endmodule
